// ===== hw/rtl/round_robin_task_scheduler_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the task scheduler
// Clocked, reset-qualified concurrent assertion wrappers.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_UNIT_DEFINES_SVH

// Assert a property on an explicit clock, disabled while reset is low.
`define RRTS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on the module's clk_i, disabled while rst_ni is low.
`define RRTS_ASSERT(label, prop, msg) \
  `RRTS_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== hw/rtl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// Task scheduler package
// Shared types, codes and defaults for the round-robin task scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrts_pkg;

  localparam int unsigned MaxTasksDefault = 16;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_EXIT   = 2'd1,
    ACT_SCHED  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STAT_CREATED   = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_SWITCHED  = 2'd2,
    STAT_NO_SWITCH = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TS_READY   = 2'd0,
    TS_RUNNING = 2'd1,
    TS_TERM    = 2'd2
  } task_state_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_REAP,
    FSM_SCAN,
    FSM_RESP
  } fsm_e;

  typedef struct packed {
    logic [31:0] id;
    task_state_e st;
    logic [31:0] pgdir;
  } entry_t;

  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [31:0] task_id;
    logic [31:0] pgdir;
  } resp_t;

endpackage

// ===== hw/rtl/rrts_in_if.sv =====
// ----------------------------------------------------------------------------
// Scheduler request channel
// Valid/ready channel carrying one scheduler request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rrts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] new_page_dir;

  modport source (output valid, output action, output new_page_dir, input ready);
  modport sink (input valid, input action, input new_page_dir, output ready);
endinterface

// ===== hw/rtl/rrts_out_if.sv =====
// ----------------------------------------------------------------------------
// Scheduler response channel
// Valid/ready channel carrying one scheduler response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rrts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] task_id;
  logic [31:0] current_page_dir;

  modport source (output valid, output status, output task_id, output current_page_dir,
                  input ready);
  modport sink (input valid, input status, input task_id, input current_page_dir,
                output ready);
endinterface

// ===== hw/rtl/round_robin_task_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// Round-robin task scheduler
// Task table with create, exit and schedule requests, one response each.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one request per transfer: action (create, exit, schedule)
//   and the page dir word of a task to create. out_o returns one response
//   per request: status, task id and the page dir of the current task.
//   cfg_we_i/cfg_wdata_i write the boot page dir; write it only while idle.
//   Before the first request it also sets the page dir of the initial task.
// Flow:
//   Create and unused actions go from idle to the response state, then to
//   the output register. Exit and schedule walk the single table read port
//   once to compact out terminated tasks and, unless one task is left, once
//   more to scan for the next ready task.
//   in_i.ready is high only while no request is in progress.
// Reset:
//   After reset the table holds task 1, running, with page dir 0; the next
//   created task gets id 2.
// Stall:
//   A response waits in the output register while out_o.ready is low; the
//   next request is taken meanwhile and holds its response until it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_task_scheduler_unit import rrts_pkg::*; #(
  parameter int unsigned MaxTasks = MaxTasksDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  rrts_in_if.sink     in_i,
  rrts_out_if.source  out_o
);

  localparam int unsigned IdxW = $clog2(MaxTasks);

  resp_t           resp;
  logic            resp_take;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [IdxW-1:0] mem_raddr;
  entry_t          mem_wdata;
  entry_t          mem_rdata;

  // Output register: holds a finished response until its transfer.
  logic        ov_q, ov_d;
  logic [1:0]  ostatus_q;
  logic [31:0] oid_q;
  logic [31:0] opd_q;

  rrts_seq #(
    .MaxTasks(MaxTasks)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .action_i      (in_i.action),
    .new_page_dir_i(in_i.new_page_dir),
    .resp_o        (resp),
    .resp_take_i   (resp_take),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  rrts_table #(
    .Depth(MaxTasks)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Load a new response when the register is empty or drains this cycle.
  assign resp_take = resp.valid && (!ov_q || out_o.ready);

  always_comb begin
    ov_d = ov_q;
    if (resp_take) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_take) begin
      ostatus_q <= resp.status;
      oid_q     <= resp.task_id;
      opd_q     <= resp.pgdir;
    end
  end

  assign out_o.valid            = ov_q;
  assign out_o.status           = ostatus_q;
  assign out_o.task_id          = oid_q;
  assign out_o.current_page_dir = opd_q;

endmodule

// ===== hw/rtl/rrts_table.sv =====
// ----------------------------------------------------------------------------
// Task table memory
// One write port, one registered read port; entries hold id, state, page dir.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrts_table import rrts_pkg::*; #(
  parameter int unsigned Depth = MaxTasksDefault,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rrts_seq.sv =====
// ----------------------------------------------------------------------------
// Task scheduler sequencer
// Walks the task table through one read port: compaction pass, then scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "round_robin_task_scheduler_unit_defines.svh"

module rrts_seq import rrts_pkg::*; #(
  parameter int unsigned MaxTasks = MaxTasksDefault,
  localparam int unsigned IdxW = $clog2(MaxTasks),
  localparam int unsigned CntW = $clog2(MaxTasks + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [31:0]     cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      action_i,
  input  logic [31:0]     new_page_dir_i,
  output resp_t           resp_o,
  input  logic            resp_take_i,
  output logic            mem_we_o,
  output logic [IdxW-1:0] mem_waddr_o,
  output entry_t          mem_wdata_o,
  output logic [IdxW-1:0] mem_raddr_o,
  input  entry_t          mem_rdata_i
);

  fsm_e state_q, state_d;

  // The current task lives in registers; its table entry is stale until it
  // is switched away from.
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] cur_q, cur_d;
  logic [31:0]     cur_id_q, cur_id_d;
  logic [31:0]     cur_pd_q, cur_pd_d;
  task_state_e     cur_st_q, cur_st_d;
  logic [31:0]     id_ctr_q, id_ctr_d;
  logic            untouched_q, untouched_d;
  status_e         status_q, status_d;

  logic [CntW-1:0] rd_q, rd_d;
  logic [CntW-1:0] wr_q, wr_d;
  logic            pv_q, pv_d;
  logic [IdxW-1:0] pa_q, pa_d;
  logic [IdxW-1:0] s_q, s_d;
  logic [CntW-1:0] k_q, k_d;

  logic            accept;
  action_e         act;
  logic            full;
  logic            reap_issue, reap_eval, reap_done, eval_cur;
  logic            scan_issue, found, scan_done;
  logic [CntW-1:0] cur_inc, s_inc;
  logic [IdxW-1:0] first_s, s_next;

  assign in_ready_o = (state_q == FSM_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign act        = action_e'(action_i);
  assign full       = (count_q == CntW'(MaxTasks));

  assign reap_issue = (state_q == FSM_REAP) && (rd_q < count_q);
  assign reap_eval  = (state_q == FSM_REAP) && pv_q;
  assign reap_done  = (state_q == FSM_REAP) && !(rd_q < count_q) && !pv_q;
  assign eval_cur   = (pa_q == cur_q);

  assign scan_issue = (state_q == FSM_SCAN) && (k_q < count_q);
  assign found      = (state_q == FSM_SCAN) && pv_q && (mem_rdata_i.st == TS_READY);
  assign scan_done  = (state_q == FSM_SCAN) && !found && !(k_q < count_q) && !pv_q;

  // Circular successors: wrap at the live task count.
  assign cur_inc = CntW'(cur_q) + CntW'(1);
  assign first_s = (cur_inc == wr_q) ? '0 : cur_inc[IdxW-1:0];
  assign s_inc   = CntW'(s_q) + CntW'(1);
  assign s_next  = (s_inc == count_q) ? '0 : s_inc[IdxW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          unique case (act)
            ACT_EXIT, ACT_SCHED: state_d = FSM_REAP;
            default:             state_d = FSM_RESP;
          endcase
        end
      end
      FSM_REAP: begin
        if (reap_done) begin
          state_d = (wr_q == CntW'(1)) ? FSM_RESP : FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (found || scan_done) begin
          state_d = FSM_RESP;
        end
      end
      FSM_RESP: begin
        if (resp_take_i) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Outputs: table port and response
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = cur_q;
    mem_wdata_o = '{id: cur_id_q, st: cur_st_q, pgdir: cur_pd_q};
    mem_raddr_o = (state_q == FSM_REAP) ? rd_q[IdxW-1:0] : s_q;
    resp_o      = '{valid: 1'b0, status: status_q, task_id: cur_id_q, pgdir: cur_pd_q};
    unique case (state_q)
      FSM_IDLE: begin
        if (accept && act == ACT_CREATE && !full) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = count_q[IdxW-1:0];
          mem_wdata_o = '{id: id_ctr_q, st: TS_READY, pgdir: new_page_dir_i};
        end
      end
      FSM_REAP: begin
        if (reap_eval && !eval_cur && mem_rdata_i.st != TS_TERM) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = wr_q[IdxW-1:0];
          mem_wdata_o = mem_rdata_i;
        end
      end
      FSM_SCAN: begin
        // Write back the outgoing task; a running task drops to ready
        if (found) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = cur_q;
          mem_wdata_o = '{id: cur_id_q,
                          st: (cur_st_q == TS_RUNNING) ? TS_READY : cur_st_q,
                          pgdir: cur_pd_q};
        end
      end
      FSM_RESP: begin
        resp_o.valid = 1'b1;
        if (status_q == STAT_CREATED) begin
          resp_o.task_id = id_ctr_q - 32'd1;
        end
      end
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    count_d     = count_q;
    cur_d       = cur_q;
    cur_id_d    = cur_id_q;
    cur_pd_d    = cur_pd_q;
    cur_st_d    = cur_st_q;
    id_ctr_d    = id_ctr_q;
    untouched_d = untouched_q;
    status_d    = status_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    pv_d        = pv_q;
    pa_d        = pa_q;
    s_d         = s_q;
    k_d         = k_q;

    // Boot page dir reaches the initial task only before the first request
    if (cfg_we_i && untouched_q) begin
      cur_pd_d = cfg_wdata_i;
    end

    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          untouched_d = 1'b0;
          rd_d        = '0;
          wr_d        = '0;
          pv_d        = 1'b0;
          status_d    = STAT_NO_SWITCH;
          unique case (act)
            ACT_CREATE: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                count_d  = count_q + CntW'(1);
                id_ctr_d = id_ctr_q + 32'd1;
                status_d = STAT_CREATED;
              end
            end
            ACT_EXIT: cur_st_d = TS_TERM;
            default: ;
          endcase
        end
      end
      FSM_REAP: begin
        pv_d = reap_issue;
        pa_d = rd_q[IdxW-1:0];
        if (reap_issue) begin
          rd_d = rd_q + CntW'(1);
        end
        // Moving cur_q mid-pass is safe: the new slot lies below every
        // address still to be read.
        if (reap_eval) begin
          if (eval_cur) begin
            cur_d = wr_q[IdxW-1:0];
            wr_d  = wr_q + CntW'(1);
          end else if (mem_rdata_i.st != TS_TERM) begin
            wr_d = wr_q + CntW'(1);
          end
        end
        if (reap_done) begin
          count_d = wr_q;
          s_d     = first_s;
          k_d     = CntW'(1);
        end
      end
      FSM_SCAN: begin
        pv_d = scan_issue;
        pa_d = s_q;
        if (scan_issue) begin
          s_d = s_next;
          k_d = k_q + CntW'(1);
        end
        if (found) begin
          cur_d    = pa_q;
          cur_id_d = mem_rdata_i.id;
          cur_pd_d = mem_rdata_i.pgdir;
          cur_st_d = TS_RUNNING;
          status_d = STAT_SWITCHED;
        end
      end
      FSM_RESP: begin
        pv_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= CntW'(1);
      cur_q       <= '0;
      cur_id_q    <= 32'd1;
      cur_pd_q    <= '0;
      cur_st_q    <= TS_RUNNING;
      id_ctr_q    <= 32'd2;
      untouched_q <= 1'b1;
      status_q    <= STAT_NO_SWITCH;
      rd_q        <= '0;
      wr_q        <= '0;
      pv_q        <= 1'b0;
      pa_q        <= '0;
      s_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cur_q       <= cur_d;
      cur_id_q    <= cur_id_d;
      cur_pd_q    <= cur_pd_d;
      cur_st_q    <= cur_st_d;
      id_ctr_q    <= id_ctr_d;
      untouched_q <= untouched_d;
      status_q    <= status_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      pv_q        <= pv_d;
      pa_q        <= pa_d;
      s_q         <= s_d;
      k_q         <= k_d;
    end
  end

  `RRTS_ASSERT(a_count_range, (count_q != '0) && (count_q <= CntW'(MaxTasks)), "task count out of range")
  `RRTS_ASSERT(a_cur_below_count, CntW'(cur_q) < count_q, "current slot beyond live tasks")
  `RRTS_ASSERT(a_reap_write_order, (mem_we_o && state_q == FSM_REAP) |-> (mem_waddr_o <= pa_q), "compaction overtakes read")
  `RRTS_ASSERT(a_switch_running, found |=> (cur_st_q == TS_RUNNING && state_q == FSM_RESP), "switch did not settle")

endmodule
